### rtl/kshist_pkg.sv
// package: widths, kinds and shared types for the keyed sample history table
`default_nettype none
package kshist_pkg;
	localparam int KEY_W = 48;
	localparam int SAMPLE_W = 8;
	localparam int DEF_TABLE_ENTRIES = 32;
	localparam int DEF_HISTORY_DEPTH = 16;
	localparam int COUNT_W = 5;
	localparam int POS_W = 4;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [KEY_W-1:0]    key;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [COUNT_W-1:0]  count;
		logic [POS_W-1:0]    position;
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} out_item_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic                match_en;
		logic                push_en;
		logic                alloc_en;
		logic                clear_en;
		logic                shift_en;
		logic [KEY_W-1:0]    key;
		logic [SAMPLE_W-1:0] sample;
	} cell_ctrl_t;
endpackage
`default_nettype wire

### rtl/kshist_if.sv
// valid/ready channel interfaces for the input and result streams
`default_nettype none
interface kshist_in_if;
	import kshist_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	logic [KEY_W-1:0]    key;
	logic [SAMPLE_W-1:0] sample;
	modport source (output valid, kind, key, sample, input ready);
	modport sink (input valid, kind, key, sample, output ready);
endinterface

interface kshist_out_if;
	import kshist_pkg::*;
	logic                valid;
	logic                ready;
	logic                found;
	logic [COUNT_W-1:0]  count;
	logic [POS_W-1:0]    position;
	logic [SAMPLE_W-1:0] value;
	logic                last;
	modport source (output valid, found, count, position, value, last, input ready);
	modport sink (input valid, found, count, position, value, last, output ready);
endinterface
`default_nettype wire

### rtl/kshist_cell.sv
// one table entry: key, fill count and a sample window that rotates out on query
`default_nettype none
module kshist_cell #(
	parameter int HISTORY_DEPTH = 16,
	parameter int FILL_W = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire kshist_pkg::cell_ctrl_t             ctrl,
	input  wire logic                               prev_used,
	output logic                                    used,
	output logic                                    hit,
	output logic [FILL_W-1:0]                       fill,
	output logic [kshist_pkg::SAMPLE_W-1:0]         head
);
	import kshist_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);

	logic                used_q;
	logic                hit_q;
	logic [KEY_W-1:0]    key_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SAMPLE_W-1:0] hist_q [HISTORY_DEPTH];

	assign used = used_q;
	assign hit  = hit_q;
	assign fill = fill_q;
	assign head = hist_q[0];

	// the first free cell after the used run takes a new key
	logic alloc_me;
	assign alloc_me = ctrl.alloc_en && prev_used && !used_q;

	// occupancy and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (ctrl.clear_en) used_q <= 1'b0;
			else if (alloc_me) used_q <= 1'b1;
			if (ctrl.match_en) hit_q <= used_q && (key_q == ctrl.key);
		end
	end

	// key, fill and window; a query rotates the window by fill steps
	always_ff @(posedge clk) begin
		if (alloc_me) begin
			key_q     <= ctrl.key;
			fill_q    <= FILL_W'(1);
			hist_q[0] <= ctrl.sample;
		end else if (ctrl.push_en && hit_q) begin
			if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
				hist_q[IDX_W'(fill_q)] <= ctrl.sample;
				fill_q <= fill_q + FILL_W'(1);
			end else begin
				for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_q[k] <= hist_q[k+1];
				hist_q[HISTORY_DEPTH-1] <= ctrl.sample;
			end
		end else if (ctrl.shift_en && hit_q) begin
			for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_q[k] <= hist_q[k+1];
			hist_q[IDX_W'(fill_q - FILL_W'(1))] <= hist_q[0];
		end
	end
endmodule
`default_nettype wire

### rtl/keyed_sample_history_table.sv
// top level: cell row plus the item sequencer and result register
//
// Usage: items enter on in_ch (kind, key, sample), results leave on out_ch.
// A push compares its key against all cells at once, in the steps accept,
// match and update. A clear and an unused kind are taken in the idle state.
// A query matches in the match and hit-check states, then, while the
// receiver keeps up, streams one result per cycle, oldest sample first, as
// the hit cell rotates its window; a miss gives one result with found low.
// A query passes through accept, match, hit check, one rotation step per
// sample and the final result transfer. When the receiver stalls, the
// result register holds and the window stops rotating; no item is taken
// until the query is done.
// Reset (arst_n low) empties the table and drops any item in flight; the
// keys and windows are left as they are and are never read until written.
`default_nettype none
module keyed_sample_history_table #(
	parameter int TABLE_ENTRIES = kshist_pkg::DEF_TABLE_ENTRIES,
	parameter int HISTORY_DEPTH = kshist_pkg::DEF_HISTORY_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kshist_in_if.sink    in_ch,
	kshist_out_if.source out_ch
);
	import kshist_pkg::*;

	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MATCH, ST_UPDATE, ST_QHIT, ST_STREAM, ST_WAIT
	} state_t;

	state_t              state_q;
	logic [1:0]          kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [FILL_W-1:0]   pos_q;
	logic [FILL_W-1:0]   n_q;
	logic                out_valid_q;
	out_item_t           out_q;

	cell_ctrl_t          ctrl;
	logic [TABLE_ENTRIES-1:0] used_v, hit_v;
	logic [FILL_W-1:0]   fill_v [TABLE_ENTRIES];
	logic [SAMPLE_W-1:0] head_v [TABLE_ENTRIES];

	logic in_xfer, out_xfer;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_valid_q && out_ch.ready;

	// cell control
	always_comb begin
		ctrl.key      = key_q;
		ctrl.sample   = sample_q;
		ctrl.match_en = (state_q == ST_MATCH);
		ctrl.push_en  = (state_q == ST_UPDATE);
		ctrl.alloc_en = (state_q == ST_UPDATE) && (hit_v == '0);
		ctrl.clear_en = in_xfer && (in_ch.kind == KIND_CLEAR);
		ctrl.shift_en = (state_q == ST_STREAM) && (!out_valid_q || out_ch.ready);
	end

	// row of cells
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic prev_used;
		if (i == 0) begin : g_first
			assign prev_used = 1'b1;
		end else begin : g_rest
			assign prev_used = used_v[i-1];
		end
		kshist_cell #(.HISTORY_DEPTH(HISTORY_DEPTH), .FILL_W(FILL_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .prev_used(prev_used),
			.used(used_v[i]), .hit(hit_v[i]),
			.fill(fill_v[i]), .head(head_v[i])
		);
	end

	// one-hot select of the hit cell's fill and window head
	logic [FILL_W-1:0]   sel_fill;
	logic [SAMPLE_W-1:0] sel_head;
	always_comb begin
		sel_fill = '0;
		sel_head = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			sel_fill |= hit_v[i] ? fill_v[i] : '0;
			sel_head |= hit_v[i] ? head_v[i] : '0;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			key_q       <= '0;
			sample_q    <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			out_q       <= '0;
		end else begin
			if (out_xfer && !ctrl.shift_en) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q   <= in_ch.kind;
						key_q    <= in_ch.key;
						sample_q <= in_ch.sample;
						if (in_ch.kind == KIND_PUSH || in_ch.kind == KIND_QUERY)
							state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= (kind_q == KIND_PUSH) ? ST_UPDATE : ST_QHIT;
				end
				ST_UPDATE: state_q <= ST_IDLE;
				ST_QHIT: begin
					pos_q <= '0;
					n_q   <= sel_fill;
					if (hit_v == '0) begin
						out_valid_q <= 1'b1;
						out_q <= '{found: 1'b0, count: '0, position: '0, value: '0, last: 1'b1};
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (ctrl.shift_en) begin
						out_valid_q    <= 1'b1;
						out_q.found    <= 1'b1;
						out_q.count    <= COUNT_W'(n_q);
						out_q.position <= POS_W'(pos_q);
						out_q.value    <= sel_head;
						out_q.last     <= (pos_q + FILL_W'(1) == n_q);
						pos_q          <= pos_q + FILL_W'(1);
						if (pos_q + FILL_W'(1) == n_q) state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_xfer) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.found    = out_q.found;
	assign out_ch.count    = out_q.count;
	assign out_ch.position = out_q.position;
	assign out_ch.value    = out_q.value;
	assign out_ch.last     = out_q.last;

`ifndef SYNTH
	// at most one cell matches a key
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_v)) else $error("several cells hit");
	// used cells form a run from cell zero
	a_used_run: assert property (@(posedge clk) disable iff (!arst_n)
		((used_v + 1'b1) & used_v) == '0) else $error("used cells not contiguous");
	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("result changed under stall");
`endif
endmodule
`default_nettype wire
